>>> sv/igcd_pkg.sv
// Shared constants and types of the central difference gradient block.
package igcd_pkg;

    localparam int MAX_WIDTH   = 1024;
    localparam int SAMPLE_BITS = 16;
    localparam int GRAD_W      = SAMPLE_BITS + 2;
    localparam int COL_W       = $clog2(MAX_WIDTH);
    localparam int ROW_W       = 16;
    localparam int LW_W        = $clog2(MAX_WIDTH + 1);
    localparam int FH_W        = 16;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = (LW_W > FH_W) ? LW_W : FH_W;
    localparam int SLOT_W      = 2;
    localparam int MEM_DEPTH   = 3 * MAX_WIDTH;
    localparam int ADDR_W      = $clog2(MEM_DEPTH);
    localparam int RES_N       = 4;

    localparam logic [LW_W-1:0] LW_RESET = LW_W'(MAX_WIDTH);
    localparam logic [FH_W-1:0] FH_RESET = FH_W'(480);
    localparam logic [LW_W-1:0] LW_MIN   = LW_W'(2);
    localparam logic [FH_W-1:0] FH_MIN   = FH_W'(2);

    localparam logic [CFG_IDX_W-1:0] CFG_LINE_WIDTH   = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = CFG_IDX_W'(1);

    typedef logic signed [SAMPLE_BITS-1:0] t_sample;

    // one column of the three newest rows
    typedef struct packed {
        t_sample up2;
        t_sample up1;
        t_sample cur;
    } t_col_vec;

    // position of an item and the edge flags derived from it
    typedef struct packed {
        logic [COL_W-1:0] col;
        logic [ROW_W-1:0] row;
        logic             col_nz;
        logic             col_one;
        logic             col_last;
        logic             row_nz;
        logic             row_one;
        logic             row_last;
    } t_pos;

endpackage

>>> sv/igcd_emit.sv
// Result sequencer: column window, gradient arithmetic and output register.
module igcd_emit (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_s1_valid,
    input  igcd_pkg::t_pos                i_pos,
    input  igcd_pkg::t_col_vec            i_vec,
    input  logic                          i_stall,
    output logic                          o_done,
    output logic                          o_valid,
    output logic [igcd_pkg::GRAD_W-1:0]   o_grad_x,
    output logic [igcd_pkg::GRAD_W-1:0]   o_grad_y,
    output logic [igcd_pkg::COL_W-1:0]    o_out_column,
    output logic [igcd_pkg::ROW_W-1:0]    o_out_row,
    output logic                          o_last_of_run,
    output logic                          o_end_of_frame
);

    igcd_pkg::t_col_vec r_p1;
    igcd_pkg::t_col_vec r_p2;
    logic [igcd_pkg::RES_N-1:0] r_sent;
    logic [igcd_pkg::RES_N-1:0] n_sent;
    logic                       r_o_valid;

    logic [igcd_pkg::RES_N-1:0] pend_all;
    logic [igcd_pkg::RES_N-1:0] pending;
    logic [igcd_pkg::RES_N-1:0] sel_hot;
    logic [igcd_pkg::RES_N-1:0] rest;
    logic [1:0]                 sel;
    logic                       out_ready;
    logic                       emit;
    logic                       k_hi;
    logic                       q_cur;
    logic                       gx_two;
    logic                       gy_two;
    igcd_pkg::t_sample          gx_a;
    igcd_pkg::t_sample          gx_b;
    igcd_pkg::t_sample          gy_a;
    igcd_pkg::t_sample          gy_b;
    igcd_pkg::t_col_vec         vcol;
    logic signed [igcd_pkg::SAMPLE_BITS:0] dx;
    logic signed [igcd_pkg::SAMPLE_BITS:0] dy;
    logic [igcd_pkg::GRAD_W-1:0] gx;
    logic [igcd_pkg::GRAD_W-1:0] gy;
    logic [igcd_pkg::COL_W-1:0]  col_k;
    logic [igcd_pkg::ROW_W-1:0]  row_q;

    // order: (c-1, r-1), (c-1, r), (W-1, r-1), (W-1, r)
    assign pend_all[0] = i_pos.col_nz & i_pos.row_nz;
    assign pend_all[1] = i_pos.col_nz & i_pos.row_last;
    assign pend_all[2] = i_pos.col_last & i_pos.row_nz;
    assign pend_all[3] = i_pos.col_last & i_pos.row_last;
    assign pending     = pend_all & ~r_sent;

    always_comb begin
        priority if (pending[0]) begin
            sel = 2'd0;
        end else if (pending[1]) begin
            sel = 2'd1;
        end else if (pending[2]) begin
            sel = 2'd2;
        end else begin
            sel = 2'd3;
        end
    end

    assign sel_hot   = igcd_pkg::RES_N'(1) << sel;
    assign rest      = pending & ~sel_hot;
    assign out_ready = !r_o_valid || !i_stall;
    assign emit      = i_s1_valid && (pending != '0) && out_ready;
    assign o_done    = i_s1_valid && ((pending == '0) || ((rest == '0) && out_ready));

    assign k_hi  = sel[1];
    assign q_cur = sel[0];

    // horizontal: same row, columns around k
    assign gx_two = k_hi || i_pos.col_one;
    assign gx_a   = q_cur ? i_vec.cur : i_vec.up1;
    always_comb begin
        if (gx_two) begin
            gx_b = q_cur ? r_p1.cur : r_p1.up1;
        end else begin
            gx_b = q_cur ? r_p2.cur : r_p2.up1;
        end
    end

    // vertical: column k, rows around q
    assign vcol   = k_hi ? i_vec : r_p1;
    assign gy_two = q_cur || i_pos.row_one;
    assign gy_a   = vcol.cur;
    assign gy_b   = gy_two ? vcol.up1 : vcol.up2;

    assign dx = {gx_a[igcd_pkg::SAMPLE_BITS-1], gx_a} - {gx_b[igcd_pkg::SAMPLE_BITS-1], gx_b};
    assign dy = {gy_a[igcd_pkg::SAMPLE_BITS-1], gy_a} - {gy_b[igcd_pkg::SAMPLE_BITS-1], gy_b};
    assign gx = gx_two ? {dx, 1'b0} : {dx[igcd_pkg::SAMPLE_BITS], dx};
    assign gy = gy_two ? {dy, 1'b0} : {dy[igcd_pkg::SAMPLE_BITS], dy};

    assign col_k = k_hi ? i_pos.col : i_pos.col - igcd_pkg::COL_W'(1);
    assign row_q = q_cur ? i_pos.row : i_pos.row - igcd_pkg::ROW_W'(1);

    always_comb begin
        n_sent = r_sent;
        if (o_done) begin
            n_sent = '0;
        end else if (emit) begin
            n_sent = r_sent | sel_hot;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sent    <= '0;
            r_o_valid <= 1'b0;
        end else begin
            r_sent    <= n_sent;
            r_o_valid <= emit || (r_o_valid && i_stall);
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_done) begin
            r_p2 <= r_p1;
            r_p1 <= i_vec;
        end
        if (emit) begin
            o_grad_x       <= gx;
            o_grad_y       <= gy;
            o_out_column   <= col_k;
            o_out_row      <= row_q;
            o_last_of_run  <= (rest == '0);
            o_end_of_frame <= (sel == 2'd3);
        end
    end

    assign o_valid = r_o_valid;

endmodule

>>> sv/image_gradient_central_difference_core.sv
// Top level of the central difference image gradient block.
// Takes signed pixels in raster order, one item per clock unless stalled, and returns the
// horizontal and vertical gradient of each pixel times two (one fractional bit), tagged
// with its column and row. Results trail the input by one row plus one pixel; the last
// row of a frame also yields its own results. The output moves one result per cycle
// unless stalled; past the first row and column a pixel yields one, a row-end or last-row
// pixel two, a frame's last pixel four. Three line stores sit in one 3 x MAX_WIDTH sample
// memory with one write and two registered reads per cycle. Width and height writes
// restart the frame. A configuration write must only be issued while the block is idle.
module image_gradient_central_difference_core (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_valid,
    output logic                               o_stall,
    input  logic [igcd_pkg::SAMPLE_BITS-1:0]   i_pixel_sample,
    output logic                               o_valid,
    input  logic                               i_stall,
    output logic [igcd_pkg::GRAD_W-1:0]        o_grad_x,
    output logic [igcd_pkg::GRAD_W-1:0]        o_grad_y,
    output logic [igcd_pkg::COL_W-1:0]         o_out_column,
    output logic [igcd_pkg::ROW_W-1:0]         o_out_row,
    output logic                               o_last_of_run,
    output logic                               o_end_of_frame,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [igcd_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [igcd_pkg::CFG_DATA_W-1:0]    i_cfg_data
);

    igcd_pkg::t_sample mem [igcd_pkg::MEM_DEPTH];

    logic [igcd_pkg::LW_W-1:0]   r_line_width;
    logic [igcd_pkg::FH_W-1:0]   r_frame_height;
    logic [igcd_pkg::COL_W-1:0]  r_col;
    logic [igcd_pkg::COL_W-1:0]  n_col;
    logic [igcd_pkg::ROW_W-1:0]  r_row;
    logic [igcd_pkg::ROW_W-1:0]  n_row;
    logic [igcd_pkg::SLOT_W-1:0] r_slot;
    logic [igcd_pkg::SLOT_W-1:0] n_slot;
    logic                        r_s1_valid;
    igcd_pkg::t_pos              r_s1_pos;
    igcd_pkg::t_sample           r_s1_px;
    igcd_pkg::t_sample           r_rd_up1;
    igcd_pkg::t_sample           r_rd_up2;

    logic [igcd_pkg::LW_W-1:0]   w_eff;
    logic [igcd_pkg::FH_W-1:0]   h_eff;
    logic [igcd_pkg::COL_W-1:0]  w_m1;
    logic [igcd_pkg::ROW_W-1:0]  h_m1;
    logic [igcd_pkg::SLOT_W-1:0] slot_m1;
    logic [igcd_pkg::SLOT_W-1:0] slot_m2;
    logic [igcd_pkg::ADDR_W-1:0] wr_addr;
    logic [igcd_pkg::ADDR_W-1:0] rd_addr1;
    logic [igcd_pkg::ADDR_W-1:0] rd_addr2;
    igcd_pkg::t_pos              pos;
    igcd_pkg::t_col_vec          s1_vec;
    logic                        cfg_fire;
    logic                        cfg_hit;
    logic                        s1_done;
    logic                        s1_adv;
    logic                        in_fire;

    function automatic logic [igcd_pkg::ADDR_W-1:0] slot_addr(
        input logic [igcd_pkg::SLOT_W-1:0] slot,
        input logic [igcd_pkg::COL_W-1:0]  col
    );
        slot_addr = igcd_pkg::ADDR_W'(slot) * igcd_pkg::ADDR_W'(igcd_pkg::MAX_WIDTH)
                  + igcd_pkg::ADDR_W'(col);
    endfunction

    assign o_cfg_ready = 1'b1;
    assign cfg_fire    = i_cfg_valid && o_cfg_ready;
    assign cfg_hit     = cfg_fire && ((i_cfg_index == igcd_pkg::CFG_LINE_WIDTH) ||
                                      (i_cfg_index == igcd_pkg::CFG_FRAME_HEIGHT));

    always_comb begin
        if (r_line_width < igcd_pkg::LW_MIN) begin
            w_eff = igcd_pkg::LW_MIN;
        end else if (r_line_width > igcd_pkg::LW_RESET) begin
            w_eff = igcd_pkg::LW_RESET;
        end else begin
            w_eff = r_line_width;
        end
    end
    assign h_eff = (r_frame_height < igcd_pkg::FH_MIN) ? igcd_pkg::FH_MIN : r_frame_height;
    assign w_m1  = igcd_pkg::COL_W'(w_eff - igcd_pkg::LW_W'(1));
    assign h_m1  = h_eff - igcd_pkg::ROW_W'(1);

    always_comb begin
        unique case (r_slot)
            2'd1: begin
                slot_m1 = 2'd0;
                slot_m2 = 2'd2;
            end
            2'd2: begin
                slot_m1 = 2'd1;
                slot_m2 = 2'd0;
            end
            default: begin
                slot_m1 = 2'd2;
                slot_m2 = 2'd1;
            end
        endcase
    end

    assign wr_addr  = slot_addr(r_slot, r_col);
    assign rd_addr1 = slot_addr(slot_m1, r_col);
    assign rd_addr2 = slot_addr(slot_m2, r_col);

    assign pos.col      = r_col;
    assign pos.row      = r_row;
    assign pos.col_nz   = (r_col != '0);
    assign pos.col_one  = (r_col == igcd_pkg::COL_W'(1));
    assign pos.col_last = (r_col == w_m1);
    assign pos.row_nz   = (r_row != '0);
    assign pos.row_one  = (r_row == igcd_pkg::ROW_W'(1));
    assign pos.row_last = (r_row == h_m1);

    assign s1_adv  = !r_s1_valid || s1_done;
    assign o_stall = !s1_adv;
    assign in_fire = i_valid && s1_adv;

    always_comb begin
        n_col  = r_col;
        n_row  = r_row;
        n_slot = r_slot;
        if (cfg_hit) begin
            n_col = '0;
            n_row = '0;
        end else if (in_fire) begin
            if (pos.col_last) begin
                n_col  = '0;
                n_slot = (r_slot == 2'd2) ? 2'd0 : r_slot + 2'd1;
                n_row  = pos.row_last ? '0 : r_row + igcd_pkg::ROW_W'(1);
            end else begin
                n_col = r_col + igcd_pkg::COL_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line_width   <= igcd_pkg::LW_RESET;
            r_frame_height <= igcd_pkg::FH_RESET;
            r_col          <= '0;
            r_row          <= '0;
            r_slot         <= '0;
            r_s1_valid     <= 1'b0;
        end else begin
            if (cfg_fire && (i_cfg_index == igcd_pkg::CFG_LINE_WIDTH)) begin
                r_line_width <= igcd_pkg::LW_W'(i_cfg_data);
            end
            if (cfg_fire && (i_cfg_index == igcd_pkg::CFG_FRAME_HEIGHT)) begin
                r_frame_height <= igcd_pkg::FH_W'(i_cfg_data);
            end
            r_col  <= n_col;
            r_row  <= n_row;
            r_slot <= n_slot;
            if (s1_adv) begin
                r_s1_valid <= in_fire;
            end
        end
    end

    // line store: new pixel in, same column of the two older rows out
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            mem[wr_addr] <= i_pixel_sample;
            r_rd_up1     <= mem[rd_addr1];
            r_rd_up2     <= mem[rd_addr2];
            r_s1_px      <= i_pixel_sample;
            r_s1_pos     <= pos;
        end
    end

    assign s1_vec.up2 = r_rd_up2;
    assign s1_vec.up1 = r_rd_up1;
    assign s1_vec.cur = r_s1_px;

    igcd_emit u_emit (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_s1_valid     (r_s1_valid),
        .i_pos          (r_s1_pos),
        .i_vec          (s1_vec),
        .i_stall        (i_stall),
        .o_done         (s1_done),
        .o_valid        (o_valid),
        .o_grad_x       (o_grad_x),
        .o_grad_y       (o_grad_y),
        .o_out_column   (o_out_column),
        .o_out_row      (o_out_row),
        .o_last_of_run  (o_last_of_run),
        .o_end_of_frame (o_end_of_frame)
    );

endmodule

>>> sv/igcd_checker.sv
// Port-level assertions for the gradient block, bound to the top level.
module igcd_checker (
    input logic                             i_clk,
    input logic                             i_rst_n,
    input logic                             i_stall,
    input logic                             o_valid,
    input logic [igcd_pkg::GRAD_W-1:0]      o_grad_x,
    input logic [igcd_pkg::GRAD_W-1:0]      o_grad_y,
    input logic [igcd_pkg::COL_W-1:0]       o_out_column,
    input logic [igcd_pkg::ROW_W-1:0]       o_out_row,
    input logic                             o_last_of_run,
    input logic                             o_end_of_frame
);

    a_reset_clears: assert property (@(posedge i_clk) !i_rst_n |=> !o_valid)
        else $error("result valid after reset");

    a_valid_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid)
        else $error("stalled result dropped");

    a_payload_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> $stable(o_grad_x) && $stable(o_grad_y) &&
            $stable(o_out_column) && $stable(o_out_row))
        else $error("stalled result changed");

    a_eof_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_end_of_frame |-> o_last_of_run)
        else $error("frame end not last of its item");

    a_frame_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_stall && o_end_of_frame ##1 o_valid |->
            (o_out_row == '0) && (o_out_column == '0))
        else $error("result after frame end not at origin");

endmodule

bind image_gradient_central_difference_core igcd_checker u_igcd_checker (.*);

>>> tb/image_gradient_central_difference_checker.sv
// Checker of the gradient block: mirrors its line stores, predicts each result, compares.
`timescale 1ns / 100ps
module image_gradient_central_difference_checker (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_pix_valid,
    input  logic                               i_pix_stall,
    input  logic [igcd_pkg::SAMPLE_BITS-1:0]   i_pixel,
    input  logic                               i_grad_valid,
    input  logic                               i_grad_stall,
    input  logic [igcd_pkg::GRAD_W-1:0]        i_grad_x,
    input  logic [igcd_pkg::GRAD_W-1:0]        i_grad_y,
    input  logic [igcd_pkg::COL_W-1:0]         i_column,
    input  logic [igcd_pkg::ROW_W-1:0]         i_row,
    input  logic                               i_last_of_run,
    input  logic                               i_end_of_frame,
    input  logic                               i_cfg_valid,
    input  logic                               i_cfg_ready,
    input  logic [igcd_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [igcd_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    output int                                 o_pending,
    output int                                 o_mismatches
);
    import igcd_pkg::*;

    typedef struct packed {
        logic [GRAD_W-1:0] grad_x;
        logic [GRAD_W-1:0] grad_y;
        logic [COL_W-1:0]  column;
        logic [ROW_W-1:0]  row;
        logic              last_of_run;
        logic              end_of_frame;
    } t_grad_result;

    t_grad_result     gradients_due [$];
    t_sample          line_buf [0:2][0:MAX_WIDTH-1];
    int unsigned      col_pos;
    int unsigned      row_pos;
    int unsigned      newest_slot;
    logic [LW_W-1:0]  line_width;
    logic [FH_W-1:0]  frame_height;
    int               mismatches;

    function automatic int pixel_at(input int unsigned slot, input int unsigned col);
        return int'(line_buf[slot][col]);
    endfunction

    // slot of the row d rows above the newest one
    function automatic int unsigned slot_back(input int unsigned s, input int unsigned d);
        return (s + 3 - d) % 3;
    endfunction

    task automatic report_mismatch(input string msg);
        mismatches++;
        $display("gradient check: %s", msg);
    endtask

    task automatic apply_config(input logic [CFG_IDX_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] data);
        if (idx == CFG_LINE_WIDTH) begin
            line_width = data[LW_W-1:0];
            col_pos = 0;
            row_pos = 0;
        end else if (idx == CFG_FRAME_HEIGHT) begin
            frame_height = data[FH_W-1:0];
            col_pos = 0;
            row_pos = 0;
        end
    endtask

    task automatic predict_gradients(input t_sample px);
        int unsigned  w;
        int unsigned  h;
        int unsigned  r;
        int unsigned  c;
        int unsigned  s;
        int unsigned  k;
        int unsigned  q;
        int unsigned  sq;
        int unsigned  cols [2];
        int           ncols;
        int           n;
        bit           take;
        int           gx;
        int           gy;
        t_grad_result batch [4];
        w = line_width;
        if (w < 2) w = 2;
        if (w > MAX_WIDTH) w = MAX_WIDTH;
        h = frame_height;
        if (h < 2) h = 2;
        if (col_pos >= w) col_pos = 0;
        if (row_pos >= h) row_pos = 0;
        r = row_pos;
        c = col_pos;
        s = newest_slot;
        line_buf[s][c] = px;

        ncols = 0;
        if (c >= 1) begin
            cols[ncols] = c - 1;
            ncols++;
        end
        if (c == w - 1) begin
            cols[ncols] = w - 1;
            ncols++;
        end

        n = 0;
        for (int i = 0; i < ncols; i++) begin
            for (int j = 0; j < 2; j++) begin
                k = cols[i];
                if (j == 0) begin
                    take = (r >= 1);
                    q = r - 1;
                end else begin
                    take = (r == h - 1);
                    q = r;
                end
                if (take) begin
                    sq = slot_back(s, r - q);
                    if (k == 0)
                        gx = 2 * (pixel_at(sq, 1) - pixel_at(sq, 0));
                    else if (k == w - 1)
                        gx = 2 * (pixel_at(sq, k) - pixel_at(sq, k - 1));
                    else
                        gx = pixel_at(sq, k + 1) - pixel_at(sq, k - 1);
                    if (q == 0)
                        gy = 2 * (pixel_at(slot_back(s, r - 1), k) - pixel_at(sq, k));
                    else if (q == h - 1)
                        gy = 2 * (pixel_at(sq, k) - pixel_at(slot_back(s, r - q + 1), k));
                    else
                        gy = pixel_at(slot_back(s, r - q - 1), k)
                           - pixel_at(slot_back(s, r - q + 1), k);
                    batch[n].grad_x       = GRAD_W'(gx);
                    batch[n].grad_y       = GRAD_W'(gy);
                    batch[n].column       = COL_W'(k);
                    batch[n].row          = ROW_W'(q);
                    batch[n].last_of_run  = 1'b0;
                    batch[n].end_of_frame = (q == h - 1) && (k == w - 1);
                    n++;
                end
            end
        end
        if (n > 0) batch[n-1].last_of_run = 1'b1;
        for (int i = 0; i < n; i++)
            gradients_due.push_back(batch[i]);

        if (c == w - 1) begin
            col_pos = 0;
            newest_slot = (s + 1) % 3;
            row_pos = (r == h - 1) ? 0 : r + 1;
        end else begin
            col_pos = c + 1;
        end
    endtask

    task automatic check_gradient();
        t_grad_result want;
        if (gradients_due.size() == 0) begin
            report_mismatch($sformatf("result with nothing expected at row %0d col %0d",
                                      i_row, i_column));
        end else begin
            want = gradients_due.pop_front();
            if (i_grad_x !== want.grad_x)
                report_mismatch($sformatf("grad_x at row %0d col %0d: got %0d, expected %0d",
                                          want.row, want.column, $signed(i_grad_x),
                                          $signed(want.grad_x)));
            if (i_grad_y !== want.grad_y)
                report_mismatch($sformatf("grad_y at row %0d col %0d: got %0d, expected %0d",
                                          want.row, want.column, $signed(i_grad_y),
                                          $signed(want.grad_y)));
            if (i_column !== want.column)
                report_mismatch($sformatf("column: got %0d, expected %0d",
                                          i_column, want.column));
            if (i_row !== want.row)
                report_mismatch($sformatf("row: got %0d, expected %0d", i_row, want.row));
            if (i_last_of_run !== want.last_of_run)
                report_mismatch($sformatf("last_of_run at row %0d col %0d: got %b, expected %b",
                                          want.row, want.column, i_last_of_run,
                                          want.last_of_run));
            if (i_end_of_frame !== want.end_of_frame)
                report_mismatch($sformatf("end_of_frame at row %0d col %0d: got %b, expected %b",
                                          want.row, want.column, i_end_of_frame,
                                          want.end_of_frame));
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            gradients_due.delete();
            col_pos = 0;
            row_pos = 0;
            newest_slot = 0;
            line_width = LW_RESET;
            frame_height = FH_RESET;
            mismatches = 0;
        end else begin
            if (i_cfg_valid && i_cfg_ready)
                apply_config(i_cfg_index, i_cfg_data);
            if (i_pix_valid && !i_pix_stall)
                predict_gradients(t_sample'(i_pixel));
            if (i_grad_valid && !i_grad_stall)
                check_gradient();
        end
        o_pending <= gradients_due.size();
        o_mismatches <= mismatches;
    end

endmodule

>>> tb/image_gradient_central_difference_core_test.sv
// Testbench top of the gradient block: clock, reset, pixel and register stimulus, verdict.
`timescale 1ns / 100ps
module image_gradient_central_difference_core_test;
    import igcd_pkg::*;

    localparam int IDLE_LIMIT    = 4000;
    localparam int SETTLE_CYCLES = 16;
    localparam int RANDOM_ITEMS  = 290;
    localparam int CALM_ITEMS    = 80;

    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = CFG_IDX_W'(3);

    localparam t_sample PIX_MAX = 16'sh7FFF;
    localparam t_sample PIX_MIN = 16'sh8000;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  pix_valid = 1'b0;
    logic                  pix_stall;
    t_sample               pixel = '0;
    logic                  grad_valid;
    logic                  grad_stall = 1'b0;
    logic [GRAD_W-1:0]     grad_x;
    logic [GRAD_W-1:0]     grad_y;
    logic [COL_W-1:0]      grad_column;
    logic [ROW_W-1:0]      grad_row;
    logic                  grad_last;
    logic                  grad_eof;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    int pending;
    int mismatches;
    int sent_items = 0;
    int stall_left = 0;
    int quiet_cycles = 0;
    bit idle_on = 1'b1;
    int frame_w = MAX_WIDTH;
    int frame_h = 480;

    always #4 clk = ~clk;

    image_gradient_central_difference_core dut (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_valid        (pix_valid),
        .o_stall        (pix_stall),
        .i_pixel_sample (pixel),
        .o_valid        (grad_valid),
        .i_stall        (grad_stall),
        .o_grad_x       (grad_x),
        .o_grad_y       (grad_y),
        .o_out_column   (grad_column),
        .o_out_row      (grad_row),
        .o_last_of_run  (grad_last),
        .o_end_of_frame (grad_eof),
        .i_cfg_valid    (cfg_valid),
        .o_cfg_ready    (cfg_ready),
        .i_cfg_index    (cfg_index),
        .i_cfg_data     (cfg_data)
    );

    image_gradient_central_difference_checker chk (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_pix_valid    (pix_valid),
        .i_pix_stall    (pix_stall),
        .i_pixel        (pixel),
        .i_grad_valid   (grad_valid),
        .i_grad_stall   (grad_stall),
        .i_grad_x       (grad_x),
        .i_grad_y       (grad_y),
        .i_column       (grad_column),
        .i_row          (grad_row),
        .i_last_of_run  (grad_last),
        .i_end_of_frame (grad_eof),
        .i_cfg_valid    (cfg_valid),
        .i_cfg_ready    (cfg_ready),
        .i_cfg_index    (cfg_index),
        .i_cfg_data     (cfg_data),
        .o_pending      (pending),
        .o_mismatches   (mismatches)
    );

    // output back-pressure in bursts
    always @(posedge clk) begin
        if (!rst_n) begin
            grad_stall <= 1'b0;
            stall_left <= 0;
        end else if (stall_left > 1) begin
            stall_left <= stall_left - 1;
        end else if (stall_left == 1) begin
            stall_left <= 0;
            grad_stall <= 1'b0;
        end else if (idle_on && $urandom_range(0, 5) == 0) begin
            grad_stall <= 1'b1;
            stall_left <= $urandom_range(1, 10);
        end
    end

    always @(posedge clk) begin
        if (!rst_n || (pix_valid && !pix_stall) || (grad_valid && !grad_stall)
                || (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= IDLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    function automatic t_sample pick_pixel(input bit harsh);
        if (harsh) begin
            case ($urandom_range(0, 4))
                0: return PIX_MAX;
                1: return PIX_MIN;
                2: return '0;
                3: return -16'sd1;
                default: return t_sample'($urandom);
            endcase
        end
        return t_sample'($urandom);
    endfunction

    task automatic send_pixel(input t_sample value);
        if (idle_on && $urandom_range(0, 5) == 0) begin
            pix_valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge clk);
        end
        pix_valid <= 1'b1;
        pixel <= value;
        do @(posedge clk); while (pix_stall);
        sent_items++;
    endtask

    task automatic send_pixels(input int count, input bit harsh);
        for (int i = 0; i < count; i++)
            send_pixel(pick_pixel(harsh));
    endtask

    // let every outstanding result drain and the pipeline empty out
    task automatic settle_block();
        pix_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        do @(posedge clk); while (!cfg_ready);
    endtask

    task automatic reconfigure(input bit set_w, input logic [CFG_DATA_W-1:0] w_data,
                               input bit set_h, input logic [CFG_DATA_W-1:0] h_data,
                               input bit poke_spare);
        settle_block();
        if (set_w) begin
            cfg_write(CFG_LINE_WIDTH, w_data);
            frame_w = int'(w_data[LW_W-1:0]);
            if (frame_w < 2) frame_w = 2;
            if (frame_w > MAX_WIDTH) frame_w = MAX_WIDTH;
        end
        if (set_h) begin
            cfg_write(CFG_FRAME_HEIGHT, h_data);
            frame_h = int'(h_data[FH_W-1:0]);
            if (frame_h < 2) frame_h = 2;
        end
        if (poke_spare) begin
            cfg_write(CFG_SPARE_A, CFG_DATA_W'($urandom));
            cfg_write(CFG_SPARE_B, CFG_DATA_W'($urandom));
        end
        cfg_valid <= 1'b0;
    endtask

    initial begin
        int start_items;
        int rand_items;
        int count;
        bit harsh;
        logic [CFG_DATA_W-1:0] w_data;
        logic [CFG_DATA_W-1:0] h_data;

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // 3x3 checkerboard of full-scale values: largest gradients of both signs
        reconfigure(1'b1, CFG_DATA_W'(3), 1'b1, CFG_DATA_W'(3), 1'b0);
        for (int i = 0; i < 9; i++)
            send_pixel((((i / 3) + (i % 3)) % 2) ? PIX_MIN : PIX_MAX);
        // unlisted indexes leave the frame running; the frame is then cut short
        reconfigure(1'b0, CFG_DATA_W'(0), 1'b0, CFG_DATA_W'(0), 1'b1);
        send_pixels(6, 1'b1);
        // sizes below the minimum act as 2x2
        reconfigure(1'b1, CFG_DATA_W'(1), 1'b1, CFG_DATA_W'(1), 1'b0);
        send_pixel(PIX_MIN);
        send_pixel(PIX_MAX);
        send_pixel(PIX_MAX);
        send_pixel(PIX_MIN);
        reconfigure(1'b1, CFG_DATA_W'(0), 1'b1, CFG_DATA_W'(0), 1'b0);
        send_pixels(4, 1'b1);

        // width clamped from above, part of a first row; then the tallest frame setting
        reconfigure(1'b1, 16'h07FF, 1'b1, CFG_DATA_W'(2), 1'b0);
        send_pixels(40, 1'b0);
        reconfigure(1'b1, 16'hF802, 1'b1, 16'hFFFF, 1'b0);
        send_pixels(60, 1'b1);

        start_items = sent_items;
        rand_items = 0;
        while (rand_items < RANDOM_ITEMS) begin
            if (rand_items >= RANDOM_ITEMS - CALM_ITEMS)
                idle_on <= 1'b0;
            else
                idle_on <= ($urandom_range(0, 4) != 0);
            case ($urandom_range(0, 9))
                0: w_data = CFG_DATA_W'($urandom_range(0, 1));
                1: w_data = CFG_DATA_W'($urandom_range(9, 40));
                default: w_data = CFG_DATA_W'($urandom_range(2, 8));
            endcase
            if (w_data > 8)
                h_data = CFG_DATA_W'($urandom_range(0, 3));
            else
                h_data = CFG_DATA_W'($urandom_range(0, 7));
            if ($urandom_range(0, 3) == 0)
                w_data[CFG_DATA_W-1:LW_W] = (CFG_DATA_W - LW_W)'($urandom);
            reconfigure($urandom_range(0, 5) != 0, w_data, $urandom_range(0, 5) != 0, h_data,
                        $urandom_range(0, 7) == 0);
            harsh = ($urandom_range(0, 3) == 0);
            if ($urandom_range(0, 3) == 0)
                count = $urandom_range(1, 2 * frame_w * frame_h);
            else
                count = $urandom_range(1, 2) * frame_w * frame_h;
            if (count > RANDOM_ITEMS - rand_items)
                count = RANDOM_ITEMS - rand_items;
            send_pixels(count, harsh);
            rand_items = sent_items - start_items;
        end

        settle_block();
        if (mismatches == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
